// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/sbsbc_pkg.sv =====
// Types, constants and helpers for the popcount sorter.
`timescale 1ns / 1ps
package sbsbc_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned DEPTH_DEF   = 64;
  localparam int unsigned NUM_BUCKETS = WORD_BITS + 1;

  typedef struct packed {
    logic [WORD_BITS-1:0] word_in;
    logic                 set_end;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word_out;
    logic [CNT_W-1:0]     ones_count;
    logic                 final_word;
    logic                 overflow;
  } out_item_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      n = n + CNT_W'(w[i]);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/sort_by_set_bit_count_top.sv =====
// A stored word is written and its count-table entry read, then the entry is updated; after the
// last word come a prefix pass over the 33 count buckets and a scatter of each word (states
// SC_RDA, SC_RDH, SC_WR), then the results, one at a time while the output is not stalled.
// Loading and scattering are paced by the read/modify/write of the count table.
// After the last result, a pass over the 33 count buckets clears the count table before the next set.
// Reset: async, active low; the same clear runs first with the input stalled.
`timescale 1ns / 1ps
module sort_by_set_bit_count_top #(
  parameter int unsigned DEPTH = sbsbc_pkg::DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sbsbc_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sbsbc_pkg::out_item_t  out_data_o
);
  import sbsbc_pkg::*;

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned FW  = $clog2(DEPTH + 1);
  localparam int unsigned HAW = $clog2(NUM_BUCKETS);
  localparam int unsigned EW  = WORD_BITS + CNT_W;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_LOAD,
    ST_LD_WR,
    ST_PFX_RD,
    ST_PFX_WR,
    ST_SC_RDA,
    ST_SC_RDH,
    ST_SC_WR,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [FW-1:0]   fill_q;
  logic            drop_q;
  logic            last_q;
  logic [HAW-1:0]  bkt_q;
  logic [FW-1:0]   run_q;
  logic [FW-1:0]   idx_q;
  logic            inflight_q;
  logic            out_valid_q;
  logic [EW-1:0]   ent_q;
  out_item_t       out_q;

  logic            in_acc;
  logic            full;
  logic [CNT_W-1:0] in_cnt;
  logic            issue;

  logic            a_we, a_re, b_we, b_re, h_we, h_re;
  logic [AW-1:0]   a_waddr, a_raddr, b_waddr, b_raddr;
  logic [HAW-1:0]  h_waddr, h_raddr;
  logic [EW-1:0]   a_wdata, a_rdata, b_rdata;
  logic [FW-1:0]   h_wdata, h_rdata;

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && (state_q == ST_LOAD);
  assign full        = (fill_q == FW'(DEPTH));
  assign in_cnt      = popcount(in_data_i.word_in);
  assign issue       = (state_q == ST_EMIT) && !inflight_q && (idx_q != fill_q) &&
                       (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Memory port control.
  always_comb begin
    a_we    = in_acc && !full;
    a_waddr = fill_q[AW-1:0];
    a_wdata = {in_cnt, in_data_i.word_in};
    a_re    = (state_q == ST_SC_RDA);
    a_raddr = idx_q[AW-1:0];

    b_we    = (state_q == ST_SC_WR);
    b_waddr = h_rdata[AW-1:0];
    b_re    = issue;
    b_raddr = idx_q[AW-1:0];

    h_we    = 1'b0;
    h_waddr = bkt_q;
    h_wdata = '0;
    h_re    = 1'b0;
    h_raddr = bkt_q;
    case (state_q)
      ST_CLR: begin
        h_we = 1'b1;
      end
      ST_LOAD: begin
        h_re    = in_acc && !full;
        h_raddr = HAW'(in_cnt);
      end
      ST_LD_WR: begin
        h_we    = 1'b1;
        h_wdata = h_rdata + FW'(1);
      end
      ST_PFX_RD: begin
        h_re = 1'b1;
      end
      ST_PFX_WR: begin
        h_we    = 1'b1;
        h_wdata = run_q;
      end
      ST_SC_RDH: begin
        h_re    = 1'b1;
        h_raddr = HAW'(a_rdata[EW-1 -: CNT_W]);
      end
      ST_SC_WR: begin
        h_we    = 1'b1;
        h_waddr = HAW'(ent_q[EW-1 -: CNT_W]);
        h_wdata = h_rdata + FW'(1);
      end
      default: begin
      end
    endcase
  end

  sbsbc_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_arrival_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .re_i    (a_re),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  sbsbc_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_sorted_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (ent_q),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  sbsbc_ram #(.WIDTH(FW), .DEPTH(NUM_BUCKETS)) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .re_i    (h_re),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      bkt_q       <= HAW'(WORD_BITS);
      fill_q      <= '0;
      drop_q      <= 1'b0;
      last_q      <= 1'b0;
      run_q       <= '0;
      idx_q       <= '0;
      inflight_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLR: begin
          if (bkt_q == '0) begin
            fill_q  <= '0;
            drop_q  <= 1'b0;
            state_q <= ST_LOAD;
          end else begin
            bkt_q <= bkt_q - HAW'(1);
          end
        end
        ST_LOAD: begin
          if (in_acc) begin
            last_q <= in_data_i.set_end;
            if (full) begin
              // drop the word, still honor the end marker
              drop_q <= 1'b1;
              if (in_data_i.set_end) begin
                bkt_q   <= HAW'(WORD_BITS);
                run_q   <= '0;
                state_q <= ST_PFX_RD;
              end
            end else begin
              fill_q  <= fill_q + FW'(1);
              bkt_q   <= HAW'(in_cnt);
              state_q <= ST_LD_WR;
            end
          end
        end
        ST_LD_WR: begin
          if (last_q) begin
            bkt_q   <= HAW'(WORD_BITS);
            run_q   <= '0;
            state_q <= ST_PFX_RD;
          end else begin
            state_q <= ST_LOAD;
          end
        end
        ST_PFX_RD: begin
          state_q <= ST_PFX_WR;
        end
        ST_PFX_WR: begin
          // bucket start = words in all higher buckets
          run_q <= run_q + h_rdata;
          if (bkt_q == '0) begin
            idx_q   <= '0;
            state_q <= ST_SC_RDA;
          end else begin
            bkt_q   <= bkt_q - HAW'(1);
            state_q <= ST_PFX_RD;
          end
        end
        ST_SC_RDA: begin
          state_q <= ST_SC_RDH;
        end
        ST_SC_RDH: begin
          state_q <= ST_SC_WR;
        end
        ST_SC_WR: begin
          if ((idx_q + FW'(1)) == fill_q) begin
            idx_q      <= '0;
            inflight_q <= 1'b0;
            state_q    <= ST_EMIT;
          end else begin
            idx_q   <= idx_q + FW'(1);
            state_q <= ST_SC_RDA;
          end
        end
        ST_EMIT: begin
          inflight_q <= issue;
          if (issue) begin
            idx_q <= idx_q + FW'(1);
          end
          if (inflight_q) begin
            out_valid_q <= 1'b1;
            if (idx_q == fill_q) begin
              bkt_q   <= HAW'(WORD_BITS);
              state_q <= ST_CLR;
            end
          end
        end
        default: begin
          state_q <= ST_CLR;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SC_RDH) begin
      ent_q <= a_rdata;
    end
    if (state_q == ST_EMIT && inflight_q) begin
      out_q.word_out   <= b_rdata[WORD_BITS-1:0];
      out_q.ones_count <= b_rdata[EW-1 -: CNT_W];
      out_q.final_word <= (idx_q == fill_q);
      out_q.overflow   <= drop_q;
    end
  end

endmodule

// ===== hw/rtl/sbsbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sbsbc_ram #(
  parameter int unsigned WIDTH = sbsbc_pkg::WORD_BITS,
  parameter int unsigned DEPTH = sbsbc_pkg::DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/sbsbc_chk.sv =====
// Port-level checker for the popcount sorter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sbsbc_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input sbsbc_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input sbsbc_pkg::out_item_t out_data_o
);
  import sbsbc_pkg::*;

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  // the end of a set blocks the input while the set is sorted
  `ASSERT_NEXT(a_load_gap, clk_i, rst_ni, in_valid_i && !in_stall_o && in_data_i.set_end, in_stall_o)
  // the table clear follows the last result of a set
  `ASSERT_NEXT(a_final_gap, clk_i, rst_ni,
               out_valid_o && !out_stall_i && out_data_o.final_word, !out_valid_o)
  `ASSERT_NOW(a_cnt_range, clk_i, rst_ni, out_valid_o,
              out_data_o.ones_count <= CNT_W'(WORD_BITS))

endmodule

bind sort_by_set_bit_count_top sbsbc_chk u_sbsbc_chk (.*);

// ===== test/sort_by_set_bit_count_top_test.sv =====
// Self-checking testbench for the popcount sorter: directed sets, then random sets.
`timescale 1ns / 1ps
module sort_by_set_bit_count_top_test;
  import sbsbc_pkg::*;

  localparam int unsigned STORE_DEPTH = DEPTH_DEF;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_ITEMS = 142;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned NUM_ROWS = 20;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last;
    logic                 typed;
    out_item_t            exp;
  } step_row_t;

  // The first singleton sets carry an obvious result that replaces the predictor's entry.
  localparam step_row_t DIRECTED [NUM_ROWS] = '{
    '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 6'd0,  1'b1, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 6'd32, 1'b1, 1'b0}},
    '{32'h8000_0000, 1'b1, 1'b1, '{32'h8000_0000, 6'd1,  1'b1, 1'b0}},
    '{32'h0000_0001, 1'b1, 1'b1, '{32'h0000_0001, 6'd1,  1'b1, 1'b0}},
    '{32'h0000_000F, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{32'h0000_0000, 1'b0, 1'b0, '0},
    '{32'hF000_0000, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, '0},
    '{32'h5555_5555, 1'b1, 1'b0, '0},
    '{32'h0000_0001, 1'b0, 1'b0, '0},
    '{32'h0000_0002, 1'b0, 1'b0, '0},
    '{32'h0000_0004, 1'b1, 1'b0, '0},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, '0},
    '{32'h8000_0001, 1'b0, 1'b0, '0},
    '{32'h7FFF_FFFE, 1'b0, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    '{32'hFFFF_0000, 1'b0, 1'b0, '0},
    '{32'h0000_FFFF, 1'b1, 1'b0, '0}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned mismatches = 0;

  // Predictor state: words of the open set and whether any were dropped.
  logic [WORD_BITS-1:0] set_words[$];
  logic                 set_dropped = 1'b0;
  out_item_t            sorted_q[$];

  sort_by_set_bit_count_top #(
    .DEPTH(STORE_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic predict_sorted(input in_item_t item);
    int unsigned emitted;
    out_item_t   r;
    emitted = 0;
    if (set_words.size() < STORE_DEPTH) set_words = {set_words, item.word_in};
    else set_dropped = 1'b1;
    if (item.set_end) begin
      for (int c = WORD_BITS; c >= 0; c--) begin
        foreach (set_words[i]) begin
          if ($countones(set_words[i]) == c) begin
            emitted++;
            r.word_out   = set_words[i];
            r.ones_count = CNT_W'(c);
            r.final_word = (emitted == set_words.size());
            r.overflow   = set_dropped;
            sorted_q = {sorted_q, r};
          end
        end
      end
      set_words.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic offer_word(input logic [WORD_BITS-1:0] word, input logic last);
    in_item_t item;
    item.word_in = word;
    item.set_end = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_sorted(item);
    @(negedge clk_i);
  endtask

  function automatic logic [WORD_BITS-1:0] pick_word();
    logic [WORD_BITS-1:0] w;
    w = $urandom();
    case ($urandom_range(7))
      0: w = '0;
      1: w = '1;
      2: w = WORD_BITS'(1) << $urandom_range(WORD_BITS - 1);
      3: w = ~(WORD_BITS'(1) << $urandom_range(WORD_BITS - 1));
      4: w = w & $urandom() & $urandom();
      default: ;
    endcase
    return w;
  endfunction

  function automatic int unsigned pick_set_size();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return $urandom_range(6, 1);
    if (r < 9) return $urandom_range(20, 7);
    return $urandom_range(40, 21);
  endfunction

  task automatic send_set(input int unsigned len);
    for (int unsigned n = 1; n <= len; n++) offer_word(pick_word(), n == len);
  endtask

  task automatic wait_sorted_drained();
    in_valid_i <= 1'b0;
    while (sorted_q.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_taken  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual word %h count %0d final %b ovf %b",
                 $time, out_data_o.word_out, out_data_o.ones_count,
                 out_data_o.final_word, out_data_o.overflow);
        mismatches++;
      end else begin
        want = sorted_q.pop_front();
        if (out_data_o.word_out !== want.word_out || out_data_o.ones_count !== want.ones_count ||
            out_data_o.final_word !== want.final_word ||
            out_data_o.overflow !== want.overflow) begin
          $display("%0t: expected word %h count %0d final %b ovf %b", $time, want.word_out,
                   want.ones_count, want.final_word, want.overflow);
          $display("%0t: actual   word %h count %0d final %b ovf %b", $time,
                   out_data_o.word_out, out_data_o.ones_count, out_data_o.final_word,
                   out_data_o.overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned long_len;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 24;
    recv_idle_pct = 73;
    for (int k = 0; k < NUM_ROWS; k++) begin
      offer_word(DIRECTED[k].word, DIRECTED[k].last);
      if (DIRECTED[k].typed) sorted_q[$] = DIRECTED[k].exp;
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 73;
          long_len      = STORE_DEPTH + 2;  // last word dropped, one more dropped before it
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 24;
          long_len      = STORE_DEPTH;      // store exactly full, nothing dropped
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          long_len      = STORE_DEPTH + 1;  // only the last word dropped
          hold_req      = 1'b1;
        end
      endcase
      send_set(long_len);
      sent = long_len;
      while (sent < PHASE_ITEMS) begin
        long_len = pick_set_size();
        send_set(long_len);
        sent += long_len;
      end
      wait_sorted_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sbsbc_pkg.sv
hw/rtl/sbsbc_ram.sv
hw/rtl/sort_by_set_bit_count_top.sv
hw/rtl/sbsbc_chk.sv
test/sort_by_set_bit_count_top_test.sv
